>>> rtl/cvh_pkg.sv
// shared constants, types and control structs of the gift-wrapping hull block
// no dependencies; every other file of the block imports this package
package cvh_pkg;

   localparam int MAX_POINTS = 64;
   localparam int MIN_POINTS = 3;
   localparam int COORD_BITS = 16;
   localparam int IDX_BITS   = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int SQ_BITS    = 2 * DIFF_BITS - 2;
   localparam int LEN_BITS   = SQ_BITS + 1;
   localparam int WORD_BITS  = 2 * COORD_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;
   typedef logic [LEN_BITS-1:0]          len_type;
   typedef logic [IDX_BITS-1:0]          idx_type;
   typedef logic [CNT_BITS-1:0]          cnt_type;
   typedef logic [WORD_BITS-1:0]         word_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic    wr_en;      // store the incoming point
      logic    wr_first;   // first point of a set, seeds the start search
      idx_type addr;       // store write address or scan index
      logic    rd_en;      // read point at addr
      logic    diff_en;    // edge vector from current vertex
      logic    mul_en;     // cross and square products
      logic    sum_en;     // cross product and squared length
      logic    decide_en;  // candidate update
      logic    first_i;    // scan index is zero
      logic    vtx_start;  // current vertex := start point
      logic    vtx_next;   // current vertex := candidate
      logic    emit_vtx;   // load result register with current vertex
      logic    emit_last;  // this vertex closes the run
      logic    emit_err;   // load result register with too-few-points result
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic cand_is_start;
   } stat_type;

endpackage

>>> rtl/cvh_ifs.sv
// request and response channel interfaces of the hull block
// depends on cvh_pkg for field types
interface cvh_req_if import cvh_pkg::*;;
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   logic      last_point;

   modport source (output valid, output point_x, output point_y, output last_point,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input last_point,
                   output ready);
endinterface

interface cvh_rsp_if import cvh_pkg::*;;
   logic      valid;
   logic      ready;
   coord_type hull_x;
   coord_type hull_y;
   idx_type   source_index;
   logic      last_vertex;
   logic      too_few_points;

   modport source (output valid, output hull_x, output hull_y, output source_index,
                   output last_vertex, output too_few_points, input ready);
   modport sink   (input valid, input hull_x, input hull_y, input source_index,
                   input last_vertex, input too_few_points, output ready);
endinterface

>>> rtl/cvh_ctrl.sv
// controller of the hull block: load counting, scan sequencing, result handshake
// depends on cvh_pkg
module cvh_ctrl import cvh_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_last,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_ERR    = 4'd2;
   localparam logic [3:0] S_READ   = 4'd3;
   localparam logic [3:0] S_DIFF   = 4'd4;
   localparam logic [3:0] S_MUL    = 4'd5;
   localparam logic [3:0] S_SUM    = 4'd6;
   localparam logic [3:0] S_DECIDE = 4'd7;
   localparam logic [3:0] S_EMIT   = 4'd8;

   logic [3:0] state_ff, state_in;
   cnt_type    cnt_ff, cnt_in;     // points stored in the current set
   cnt_type    n_ff, n_in;         // size of the set being wrapped
   idx_type    i_ff, i_in;         // scan index
   idx_type    len_ff, len_in;     // vertices emitted so far
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept, has_room, emit_ok, last_i;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign has_room  = (cnt_ff < CNT_BITS'(MAX_POINTS));
   assign emit_ok   = !rsp_valid_ff || rsp_ready;
   assign last_i    = ({1'b0, i_ff} == (n_ff - CNT_BITS'(1)));
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.addr     = (state_ff == S_IDLE) ? cnt_ff[IDX_BITS-1:0] : i_ff;
      cmd.first_i  = (i_ff == '0);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (has_room) begin
                  cmd.wr_en    = 1'b1;
                  cmd.wr_first = (cnt_ff == '0);
                  cnt_in       = cnt_ff + CNT_BITS'(1);
               end
               if (req_last) begin
                  n_in     = has_room ? cnt_ff + CNT_BITS'(1) : cnt_ff;
                  cnt_in   = '0;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (n_ff < CNT_BITS'(MIN_POINTS)) begin
               state_in = S_ERR;
            end else begin
               cmd.vtx_start = 1'b1;
               i_in          = '0;
               len_in        = '0;
               state_in      = S_READ;
            end
         end
         S_ERR: begin
            if (emit_ok) begin
               cmd.emit_err = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff_en = 1'b1;
            state_in    = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_SUM;
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide_en = 1'b1;
            if (last_i) begin
               state_in = S_EMIT;
            end else begin
               i_in     = i_ff + IDX_BITS'(1);
               state_in = S_READ;
            end
         end
         S_EMIT: begin
            if (emit_ok) begin
               cmd.emit_vtx  = 1'b1;
               cmd.emit_last = stat.cand_is_start || (len_ff == IDX_BITS'(MAX_POINTS - 1));
               rsp_valid_in  = 1'b1;
               len_in        = len_ff + IDX_BITS'(1);
               if (cmd.emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.vtx_next = 1'b1;
                  i_in         = '0;
                  state_in     = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         n_ff         <= '0;
         i_ff         <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/cvh_dp.sv
// datapath of the hull block: point store, start search, edge tests, result register
// depends on cvh_pkg
module cvh_dp import cvh_pkg::*; (
   input  logic      clock,
   input  coord_type point_x,
   input  coord_type point_y,
   input  cmd_type   cmd,
   output stat_type  stat,
   output coord_type hull_x,
   output coord_type hull_y,
   output idx_type   source_index,
   output logic      last_vertex,
   output logic      too_few_points
);

   word_type  mem [MAX_POINTS];
   word_type  rd_data_ff;
   coord_type rd_x, rd_y;

   idx_type   start_idx_ff;
   coord_type start_x_ff, start_y_ff;
   idx_type   cur_idx_ff;
   coord_type cx_ff, cy_ff;
   diff_type  e2x_ff, e2y_ff;
   prod_type  m1_ff, m2_ff, s1_ff, s2_ff;
   cross_type cross_ff;
   len_type   len2_ff;
   idx_type   cand_idx_ff;
   diff_type  e1x_ff, e1y_ff;
   len_type   len1_ff;
   coord_type cand_x_ff, cand_y_ff;
   coord_type hull_x_ff, hull_y_ff;
   idx_type   src_ff;
   logic      last_ff, err_ff;
   logic      better_start, take;

   assign rd_x = rd_data_ff[COORD_BITS-1:0];
   assign rd_y = rd_data_ff[WORD_BITS-1:COORD_BITS];

   // point store
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= {point_y, point_x};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   // rightmost point, lowest y on a tie, tracked while loading
   assign better_start = (point_x > start_x_ff) ||
                         ((point_x == start_x_ff) && (point_y < start_y_ff));

   always_ff @(posedge clock) begin
      if (cmd.wr_en && (cmd.wr_first || better_start)) begin
         start_idx_ff <= cmd.addr;
         start_x_ff   <= point_x;
         start_y_ff   <= point_y;
      end
   end

   // current vertex
   always_ff @(posedge clock) begin
      if (cmd.vtx_start) begin
         cur_idx_ff <= start_idx_ff;
         cx_ff      <= start_x_ff;
         cy_ff      <= start_y_ff;
      end else if (cmd.vtx_next) begin
         cur_idx_ff <= cand_idx_ff;
         cx_ff      <= cand_x_ff;
         cy_ff      <= cand_y_ff;
      end
   end

   // edge test pipeline, one step per command
   always_ff @(posedge clock) begin
      if (cmd.diff_en) begin
         e2x_ff <= DIFF_BITS'(rd_x) - DIFF_BITS'(cx_ff);
         e2y_ff <= DIFF_BITS'(rd_y) - DIFF_BITS'(cy_ff);
      end
      if (cmd.mul_en) begin
         m1_ff <= PROD_BITS'(e1x_ff) * PROD_BITS'(e2y_ff);
         m2_ff <= PROD_BITS'(e1y_ff) * PROD_BITS'(e2x_ff);
         s1_ff <= PROD_BITS'(e2x_ff) * PROD_BITS'(e2x_ff);
         s2_ff <= PROD_BITS'(e2y_ff) * PROD_BITS'(e2y_ff);
      end
      if (cmd.sum_en) begin
         cross_ff <= CROSS_BITS'(m1_ff) - CROSS_BITS'(m2_ff);
         len2_ff  <= {1'b0, s1_ff[SQ_BITS-1:0]} + {1'b0, s2_ff[SQ_BITS-1:0]};
      end
   end

   // clockwise-most point wins, farther one when collinear
   assign take = cmd.first_i || (cand_idx_ff == cur_idx_ff) || cross_ff[CROSS_BITS-1] ||
                 ((cross_ff == '0) && (len2_ff > len1_ff));

   always_ff @(posedge clock) begin
      if (cmd.decide_en && take) begin
         cand_idx_ff <= cmd.addr;
         e1x_ff      <= e2x_ff;
         e1y_ff      <= e2y_ff;
         len1_ff     <= len2_ff;
         cand_x_ff   <= rd_x;
         cand_y_ff   <= rd_y;
      end
   end

   assign stat.cand_is_start = (cand_idx_ff == start_idx_ff);

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit_vtx) begin
         hull_x_ff <= cx_ff;
         hull_y_ff <= cy_ff;
         src_ff    <= cur_idx_ff;
         last_ff   <= cmd.emit_last;
         err_ff    <= 1'b0;
      end else if (cmd.emit_err) begin
         hull_x_ff <= '0;
         hull_y_ff <= '0;
         src_ff    <= '0;
         last_ff   <= 1'b1;
         err_ff    <= 1'b1;
      end
   end

   assign hull_x         = hull_x_ff;
   assign hull_y         = hull_y_ff;
   assign source_index   = src_ff;
   assign last_vertex    = last_ff;
   assign too_few_points = err_ff;

endmodule

>>> rtl/convex_hull_gift_wrap.sv
// top level of the gift-wrapping 2d convex hull block
// depends on cvh_pkg, cvh_ifs (channel interfaces), cvh_ctrl and cvh_dp
//
//   channel  dir  payload                                              
//   req_ch   in   point_x, point_y, last_point                        
//   rsp_ch   out  hull_x, hull_y, source_index, last_vertex, too_few_points
//
// a request that is not last is stored as it is accepted; up to 64 points per set, more are dropped
// a last request passes through a check state, then each hull vertex takes one pass
// of the shared cross-product unit over the stored points, each point in turn going
// through store read, edge vector, products, sums and candidate update
// a result waits in the output register; only the next vertex stalls behind it
// reset clears the controller; the point store needs no clearing
module convex_hull_gift_wrap import cvh_pkg::*; (
   input logic       clock,
   input logic       reset,
   cvh_req_if.sink   req_ch,
   cvh_rsp_if.source rsp_ch
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: load counting, scan steps, result handshake
   cvh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_last  (req_ch.last_point),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // point store, start search, orientation test, result register
   cvh_dp u_dp (
      .clock          (clock),
      .point_x        (req_ch.point_x),
      .point_y        (req_ch.point_y),
      .cmd            (cmd),
      .stat           (stat),
      .hull_x         (rsp_ch.hull_x),
      .hull_y         (rsp_ch.hull_y),
      .source_index   (rsp_ch.source_index),
      .last_vertex    (rsp_ch.last_vertex),
      .too_few_points (rsp_ch.too_few_points)
   );

endmodule

>>> dv/tb_convex_hull_gift_wrap.sv
// self-checking testbench of the gift-wrapping convex hull block
// depends on cvh_pkg and the channel interfaces of cvh_ifs; predicts each hull in place
module tb_convex_hull_gift_wrap;
   import cvh_pkg::*;

   // one expected response of the block
   typedef struct {
      coord_type x;
      coord_type y;
      idx_type   index;
      logic      last;
      logic      too_few;
   } hull_vertex_type;

   // how the points of a random set are drawn
   typedef enum int {MODE_WIDE, MODE_GRID, MODE_LINE, MODE_EXTREME} point_mode_type;

   // a full set is wrapped with one scan per vertex, so one scan of a full store
   // plus some slack covers anything still in flight
   localparam int DRAIN_CYCLES = 5 * MAX_POINTS + 20;
   localparam int REPORT_LINES = 40;

   logic clock = 1'b0;
   logic reset;

   cvh_req_if req_ch();
   cvh_rsp_if rsp_ch();

   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count;

   // vertices still owed by the block, oldest first
   hull_vertex_type pending_vertices[$];

   // points of the set being loaded, as the block stores them
   coord_type set_x[MAX_POINTS];
   coord_type set_y[MAX_POINTS];
   int        set_count;

   coord_type extreme_values[7] = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1,
                                    16'sh7ffe, 16'sh7fff};

   convex_hull_gift_wrap dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // gift-wrap the stored set and queue the vertices the block must emit
   function automatic void wrap_hull();
      int n, i, k, start, cur, cand, hull_len;
      int order[MAX_POINTS];
      longint cx, cy, e1x, e1y, e2x, e2y, cross_val, len1, len2;
      hull_vertex_type v;
      n = set_count;
      set_count = 0;
      if (n < MIN_POINTS) begin
         v = '{x: '0, y: '0, index: '0, last: 1'b1, too_few: 1'b1};
         pending_vertices.push_back(v);
         return;
      end
      // rightmost point, lowest y on a tie, earliest among identical points
      start = 0;
      for (i = 1; i < n; i++) begin
         if (set_x[i] > set_x[start])
            start = i;
         else if (set_x[i] == set_x[start] && set_y[i] < set_y[start])
            start = i;
      end
      hull_len = 0;
      cur = start;
      while (hull_len < MAX_POINTS) begin
         cx = longint'(set_x[cur]);
         cy = longint'(set_y[cur]);
         order[hull_len] = cur;
         cand = 0;
         for (i = 0; i < n; i++) begin
            if (cand == cur) begin
               cand = i;
               continue;
            end
            e1x = longint'(set_x[cand]) - cx;
            e1y = longint'(set_y[cand]) - cy;
            e2x = longint'(set_x[i]) - cx;
            e2y = longint'(set_y[i]) - cy;
            cross_val = e1x * e2y - e1y * e2x;
            len1 = e1x * e1x + e1y * e1y;
            len2 = e2x * e2x + e2y * e2y;
            // clockwise turn wins, on a collinear point the farther one wins
            if (cross_val < 0 || (cross_val == 0 && len2 > len1))
               cand = i;
         end
         hull_len++;
         cur = cand;
         if (cand == start)
            break;
      end
      // duplicates may keep the wrap from closing, then it stops at a full store
      for (k = 0; k < hull_len; k++) begin
         v.x = set_x[order[k]];
         v.y = set_y[order[k]];
         v.index = idx_type'(order[k]);
         v.last = (k == hull_len - 1);
         v.too_few = 1'b0;
         pending_vertices.push_back(v);
      end
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < REPORT_LINES)
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // one request: optional idle cycles, then hold valid until ready is seen at an edge
   task automatic send_point(input coord_type x, input coord_type y, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.point_x    <= x;
      req_ch.point_y    <= y;
      req_ch.last_point <= last;
      do
         @(posedge clock);
      while (req_ch.ready !== 1'b1);
      // points past a full store are dropped, a last flag still closes the set
      if (set_count < MAX_POINTS) begin
         set_x[set_count] = x;
         set_y[set_count] = y;
         set_count++;
      end
      if (last)
         wrap_hull();
   endtask

   // stop sending and hold off until every owed vertex has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_vertices.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_set(input int n, input point_mode_type mode);
      int k, x0, y0, dx, dy, step;
      coord_type x, y;
      x0 = int'($urandom_range(0, 2000)) - 1000;
      y0 = int'($urandom_range(0, 2000)) - 1000;
      dx = int'($urandom_range(0, 6)) - 3;
      dy = int'($urandom_range(0, 6)) - 3;
      for (k = 0; k < n; k++) begin
         case (mode)
            MODE_WIDE: begin
               x = coord_type'($urandom);
               y = coord_type'($urandom);
            end
            // tiny grid: lots of duplicates and collinear triples
            MODE_GRID: begin
               x = coord_type'(int'($urandom_range(0, 4)) - 2);
               y = coord_type'(int'($urandom_range(0, 4)) - 2);
            end
            // mostly on one line, a few points off it
            MODE_LINE: begin
               if ($urandom_range(3) == 0) begin
                  x = coord_type'(x0 + int'($urandom_range(0, 40)) - 20);
                  y = coord_type'(y0 + int'($urandom_range(0, 40)) - 20);
               end else begin
                  step = int'($urandom_range(0, 10));
                  x = coord_type'(x0 + step * dx);
                  y = coord_type'(y0 + step * dy);
               end
            end
            default: begin
               x = extreme_values[$urandom_range(0, 6)];
               y = extreme_values[$urandom_range(0, 6)];
            end
         endcase
         send_point(x, y, k == n - 1);
      end
   endtask

   // one and two points give the error response, three is the smallest hull
   task automatic test_too_few();
      send_point(16'sd100, -16'sd5, 1'b1);
      send_point(16'sh7fff, 16'sh8000, 1'b0);
      send_point(16'sh8000, 16'sh7fff, 1'b1);
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd1, 16'sd0, 1'b0);
      send_point(16'sd0, 16'sd1, 1'b1);
   endtask

   // corners of the coordinate range stress the width of the cross products
   task automatic test_extremes();
      send_point(16'sh7fff, 16'sh8000, 1'b0);
      send_point(16'sh7fff, 16'sh7fff, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sh8000, 16'sh7fff, 1'b0);
      send_point(16'sh8000, 16'sh8000, 1'b1);
   endtask

   task automatic test_ties_and_collinear();
      // several points share the largest x, start must take the lowest y
      send_point(16'sd5, 16'sd10, 1'b0);
      send_point(16'sd5, -16'sd3, 1'b0);
      send_point(16'sd5, 16'sd7, 1'b0);
      send_point(-16'sd2, 16'sd0, 1'b1);
      // points in the middle of hull edges, the farther one must win
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd10, 16'sd0, 1'b0);
      send_point(16'sd5, 16'sd0, 1'b0);
      send_point(16'sd10, 16'sd10, 1'b0);
      send_point(16'sd0, 16'sd10, 1'b0);
      send_point(16'sd10, 16'sd5, 1'b1);
      // all points identical
      send_point(16'sd3, 16'sd3, 1'b0);
      send_point(16'sd3, 16'sd3, 1'b0);
      send_point(16'sd3, 16'sd3, 1'b1);
      // duplicate of the start point
      send_point(16'sd7, 16'sd1, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd7, 16'sd1, 1'b0);
      send_point(16'sd0, 16'sd5, 1'b1);
   endtask

   task automatic test_store_limits();
      int k;
      // a full store with every point on the hull: the longest response run
      for (k = 0; k < MAX_POINTS; k++)
         send_point(coord_type'(k - 32), coord_type'((k - 32) * (k - 32)),
                    k == MAX_POINTS - 1);
      // overflow: the tail is dropped and the last flag sits on a dropped point
      for (k = 0; k < MAX_POINTS + 6; k++)
         send_point(coord_type'(int'($urandom_range(0, 8)) - 4),
                    coord_type'(int'($urandom_range(0, 8)) - 4),
                    k == MAX_POINTS + 5);
   endtask

   // mostly small sets of random shape, now and then a larger one
   task automatic test_random(input int item_budget);
      int sent, pick, n;
      sent = 0;
      while (sent < item_budget) begin
         pick = $urandom_range(99);
         if (pick < 8)
            n = $urandom_range(1, 2);
         else if (pick < 85)
            n = $urandom_range(3, 10);
         else
            n = $urandom_range(11, 30);
         send_set(n, point_mode_type'($urandom_range(0, 3)));
         sent += n;
      end
   endtask

   // response side stalls at its own rate
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // compare each accepted response with the oldest owed vertex
   always @(posedge clock) begin
      hull_vertex_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_vertices.size() == 0) begin
            report_mismatch("response with nothing pending, hull_x", rsp_ch.hull_x, 0);
         end else begin
            want = pending_vertices.pop_front();
            if (rsp_ch.hull_x !== want.x)
               report_mismatch("hull_x", rsp_ch.hull_x, want.x);
            if (rsp_ch.hull_y !== want.y)
               report_mismatch("hull_y", rsp_ch.hull_y, want.y);
            if (rsp_ch.source_index !== want.index)
               report_mismatch("source_index", rsp_ch.source_index, want.index);
            if (rsp_ch.last_vertex !== want.last)
               report_mismatch("last_vertex", rsp_ch.last_vertex, want.last);
            if (rsp_ch.too_few_points !== want.too_few)
               report_mismatch("too_few_points", rsp_ch.too_few_points, want.too_few);
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.point_x    <= '0;
      req_ch.point_y    <= '0;
      req_ch.last_point <= 1'b0;
      mismatch_count = 0;
      set_count = 0;
      send_idle_pct = 26;
      recv_idle_pct = 87;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // slow receiver
      test_too_few();
      test_extremes();
      test_ties_and_collinear();
      test_random(10);
      drain_results();

      // slow sender
      send_idle_pct = 87;
      recv_idle_pct = 26;
      test_random(10);
      test_store_limits();
      drain_results();

      // back to back
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(10);
      drain_results();

      // anything arriving now is unexpected
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // hang guard
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/cvh_pkg.sv
rtl/cvh_ifs.sv
rtl/cvh_ctrl.sv
rtl/cvh_dp.sv
rtl/convex_hull_gift_wrap.sv
dv/tb_convex_hull_gift_wrap.sv
